// ===== rtl/tcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int unsigned DEF_COLUMNS    = 80;
  localparam int unsigned DEF_ROWS       = 25;
  localparam int unsigned DEF_TAB_SPACES = 4;

  localparam logic [7:0]  CH_NEWLINE = 8'h0A;
  localparam logic [7:0]  CH_TAB     = 8'h09;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [15:0] RESET_CELL = {RESET_ATTR, CH_SPACE};

  typedef enum logic [1:0] {
    MODE_WRITE     = 2'd0,
    MODE_BACKSPACE = 2'd1,
    MODE_CLEAR     = 2'd2,
    MODE_READ      = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_PRINT,
    ST_SCROLL,
    ST_DRAIN,
    ST_BLANK,
    ST_CLEAR,
    ST_RESP
  } state_e;

endpackage : tcce_pkg
`default_nettype wire

// ===== rtl/text_console_cursor_engine_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// Character terminal: screen store of attribute/character cells and a cursor.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low; its one result
// word appears on cursor_position_o and cell_data_o together with done_o,
// which is high for exactly one cycle, and the receiver cannot stall it. A tab
// writes TAB_SPACES cells one after another, since every cell goes through the
// single write port of the screen memory. A scroll walks the whole memory
// through its one read and one write port, one cell a cycle. Clear writes a
// blank into every cell. After reset the block stays busy while it fills the
// memory with blanks; attribute writes are taken during that time.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_core
  import tcce_pkg::*;
#(
  parameter int unsigned COLUMNS    = DEF_COLUMNS,
  parameter int unsigned ROWS       = DEF_ROWS,
  parameter int unsigned TAB_SPACES = DEF_TAB_SPACES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_address_i,
  input  wire logic        text_attribute_we_i,
  input  wire logic [7:0]  text_attribute_i,
  output logic             done_o,
  output logic [10:0]      cursor_position_o,
  output logic [15:0]      cell_data_o
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned CW    = $clog2(COLUMNS + 1);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned TW    = $clog2(TAB_SPACES + 1);
  localparam int unsigned XW    = (AW > 11) ? AW : 11;

  // screen memory
  logic [15:0]   screen_mem [CELLS];
  logic [15:0]   screen_rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  state_e        state_q, state_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [7:0]    attr_q;
  logic [7:0]    ch_q, ch_d;
  logic [TW-1:0] tab_q, tab_d;
  logic          ret_q, ret_d;
  logic          rdflag_q, rdflag_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] paddr_q, paddr_d;
  logic          done_q, done_d;
  logic [10:0]   pos_q, pos_d;
  logic [15:0]   data_q, data_d;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] bs_addr;
  logic [CW-1:0] col_dec;
  logic          row_last;
  logic [XW-1:0] rd_addr_x;
  logic          rd_in_range;
  logic [15:0]   blank_cell;

  assign col_dec     = col_q - CW'(1);
  assign cur_addr    = AW'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
  assign bs_addr     = AW'(32'(row_q) * 32'(COLUMNS) + 32'(col_dec));
  assign row_last    = (row_q == RW'(ROWS - 1));
  assign rd_addr_x   = XW'(cell_address_i);
  assign rd_in_range = (rd_addr_x < XW'(CELLS));
  assign blank_cell  = {attr_q, CH_SPACE};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      screen_rdata_q <= screen_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= RESET_ATTR;
    end else if (text_attribute_we_i) begin
      attr_q <= text_attribute_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      col_q    <= '0;
      row_q    <= '0;
      tab_q    <= '0;
      ret_q    <= 1'b0;
      rdflag_q <= 1'b0;
      sweep_q  <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      tab_q    <= tab_d;
      ret_q    <= ret_d;
      rdflag_q <= rdflag_d;
      sweep_q  <= sweep_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q    <= ch_d;
    paddr_q <= paddr_d;
    pos_q   <= pos_d;
    data_q  <= data_d;
  end

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    ch_d      = ch_q;
    tab_d     = tab_q;
    ret_d     = ret_q;
    rdflag_d  = rdflag_q;
    sweep_d   = sweep_q;
    pend_d    = 1'b0;
    paddr_d   = paddr_q;
    done_d    = 1'b0;
    pos_d     = pos_q;
    data_d    = data_q;
    mem_we    = 1'b0;
    mem_waddr = cur_addr;
    mem_wdata = blank_cell;
    mem_re    = 1'b0;
    mem_raddr = sweep_q;

    case (state_q)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        mem_wdata = RESET_CELL;
        if (sweep_q == AW'(CELLS - 1)) begin
          sweep_d = '0;
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          rdflag_d = 1'b0;
          case (mode_e'(mode_i))
            MODE_WRITE: begin
              if (char_code_i == CH_NEWLINE) begin
                col_d = '0;
                ret_d = 1'b0;
                if (row_last) begin
                  sweep_d = AW'(COLUMNS);
                  state_d = ST_SCROLL;
                end else begin
                  row_d   = row_q + RW'(1);
                  state_d = ST_RESP;
                end
              end else begin
                ch_d    = (char_code_i == CH_TAB) ? CH_SPACE : char_code_i;
                tab_d   = (char_code_i == CH_TAB) ? TW'(TAB_SPACES) : TW'(1);
                state_d = ST_PRINT;
              end
            end
            MODE_BACKSPACE: begin
              if (col_q != '0) begin
                col_d     = col_dec;
                mem_we    = 1'b1;
                mem_waddr = bs_addr;
              end
              state_d = ST_RESP;
            end
            MODE_CLEAR: begin
              col_d   = '0;
              row_d   = '0;
              sweep_d = '0;
              state_d = ST_CLEAR;
            end
            MODE_READ: begin
              rdflag_d  = rd_in_range;
              mem_re    = rd_in_range;
              mem_raddr = AW'(rd_addr_x);
              state_d   = ST_RESP;
            end
            default: begin
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_PRINT: begin
        if (col_q == CW'(COLUMNS)) begin
          // pending wrap onto the next row
          col_d = '0;
          if (row_last) begin
            ret_d   = 1'b1;
            sweep_d = AW'(COLUMNS);
            state_d = ST_SCROLL;
          end else begin
            row_d = row_q + RW'(1);
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur_addr;
          mem_wdata = {attr_q, ch_q};
          col_d     = col_q + CW'(1);
          tab_d     = tab_q - TW'(1);
          if (tab_q == TW'(1)) begin
            state_d = ST_RESP;
          end
        end
      end

      ST_SCROLL: begin
        // read one row ahead, write back the cell read last cycle
        mem_re    = 1'b1;
        mem_raddr = sweep_q;
        pend_d    = 1'b1;
        paddr_d   = sweep_q - AW'(COLUMNS);
        if (pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = paddr_q;
          mem_wdata = screen_rdata_q;
        end
        if (sweep_q == AW'(CELLS - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = paddr_q;
        mem_wdata = screen_rdata_q;
        sweep_d   = AW'(CELLS - COLUMNS);
        state_d   = ST_BLANK;
      end

      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_q == AW'(CELLS - 1)) begin
          state_d = ret_q ? ST_PRINT : ST_RESP;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_q;
        if (sweep_q == AW'(CELLS - 1)) begin
          state_d = ST_RESP;
        end else begin
          sweep_d = sweep_q + AW'(1);
        end
      end

      ST_RESP: begin
        done_d  = 1'b1;
        pos_d   = 11'(32'(row_q) * 32'(COLUMNS) + 32'(col_q));
        data_d  = rdflag_q ? screen_rdata_q : 16'h0000;
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign cursor_position_o = pos_q;
  assign cell_data_o       = data_q;

  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == ST_RESP))
    else $error("result word without a response cycle");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= CW'(COLUMNS)) && (row_q <= RW'(ROWS - 1)))
    else $error("cursor out of range");

  a_scroll_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> pend_q)
    else $error("scroll drain without pending copy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("command accepted but engine not busy");

endmodule : text_console_cursor_engine_core
`default_nettype wire
